// File: hdl/dltq_pkg.sv
// dltq_pkg: sizes, codes and controller/datapath command types for the
// delta-list timer queue. No dependencies.
`timescale 1ns / 1ps
package dltq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W      = 48;
  localparam int DELTA_W     = 32;
  localparam int MODE_W      = 2;
  localparam int TID_W       = 8;
  localparam int ST_W        = 2;
  localparam int OCNT_W      = 5;

  localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_QUEUED = 2'd1;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_ADV, DP_EXP_RD, DP_EXP_CHK, DP_FIND_INIT, DP_FIND_RD,
    DP_FIND_CHK, DP_SET_ST, DP_APPEND, DP_INS_INIT, DP_INS_RD, DP_INS_CHK,
    DP_INS_PUT, DP_RM_INIT, DP_RM_RD, DP_RM_CHK, DP_RM_DONE, DP_HW_RD,
    DP_HW_SET, DP_SUM
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_ADV, S_EXP_RD, S_EXP_CHK, S_FIND_INIT, S_FIND_RD, S_FIND_CHK,
    S_INS_RD, S_INS_CHK, S_INS_PUT, S_RM_RD, S_RM_CHK, S_HW_RD, S_HW_SET, S_SUM
  } ctl_state_e;

  typedef struct packed {
    dp_op_e          op;
    logic [ST_W-1:0] st;
  } dltq_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] in_mode;
    logic [MODE_W-1:0] mode;
    logic              to_zero;
    logic              out_free;
    logic              exp_hit;
    logic              match;
    logic              ptr_at_cnt;
    logic              full;
    logic              append;
    logic              ins_brk;
    logic [CNT_W-1:0]  count;
  } dltq_sts_t;

  // Map a logical offset from the head to a physical slot of the ring.
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                            input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(head) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

// File: hdl/dltq_if.sv
// dltq_if: valid/ready channels for request and result transactions.
// Depends on dltq_pkg.
`timescale 1ns / 1ps
interface dltq_in_if;
  logic                          valid;
  logic                          ready;
  logic [dltq_pkg::MODE_W-1:0]   mode;
  logic [dltq_pkg::TID_W-1:0]    thread_id;
  logic [dltq_pkg::DELTA_W-1:0]  timeout;
  logic [dltq_pkg::TIME_W-1:0]   now_time;
  modport source (output valid, mode, thread_id, timeout, now_time, input ready);
  modport sink   (input valid, mode, thread_id, timeout, now_time, output ready);
endinterface

interface dltq_out_if;
  logic                         valid;
  logic                         ready;
  logic                         is_wake;
  logic [dltq_pkg::TID_W-1:0]   woken_id;
  logic [dltq_pkg::ST_W-1:0]    status;
  logic [dltq_pkg::OCNT_W-1:0]  entry_count;
  logic [dltq_pkg::TIME_W-1:0]  next_wake_time;
  logic                         last;
  modport source (output valid, is_wake, woken_id, status, entry_count, next_wake_time,
                  last, input ready);
  modport sink   (input valid, is_wake, woken_id, status, entry_count, next_wake_time,
                  last, output ready);
endinterface

// File: hdl/delta_list_timer_queue.sv
// delta_list_timer_queue: timer queue of sleepers kept as a delta list.
// A summary-only request goes straight to the summary; other requests walk the
// entries (expire, lookup, and insert or remove shift walk); one request is
// handled at a time.
// The entry memory (one read, one write a cycle) sets the pace.
// Reset empties the queue and zeroes the clocks; entry memory is not cleared.
`timescale 1ns / 1ps
module delta_list_timer_queue (
  input logic       clk_i,
  input logic       rst_ni,
  dltq_in_if.sink   in_i,
  dltq_out_if.source out_o
);
  import dltq_pkg::*;

  dltq_cmd_t cmd;
  dltq_sts_t sts;
  logic      in_ready;

  assign in_i.ready = in_ready;

  dltq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dltq_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .mode_i           (in_i.mode),
    .thread_id_i      (in_i.thread_id),
    .timeout_i        (in_i.timeout),
    .now_time_i       (in_i.now_time),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .is_wake_o        (out_o.is_wake),
    .woken_id_o       (out_o.woken_id),
    .status_o         (out_o.status),
    .entry_count_o    (out_o.entry_count),
    .next_wake_time_o (out_o.next_wake_time),
    .last_o           (out_o.last)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> (cmd.op == DP_LOAD))
    else $error("request transaction without load");

  a_wake_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == DP_EXP_CHK && sts.exp_hit) |-> sts.out_free)
    else $error("wake result issued while result register busy");

  a_sum_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == DP_SUM) |-> sts.out_free)
    else $error("summary issued while result register busy");

endmodule

// File: hdl/dltq_datapath.sv
// dltq_datapath: ring-buffer entry memory, queue registers and result register.
// Depends on dltq_pkg; driven by dltq_ctrl through dltq_cmd_t.
`timescale 1ns / 1ps
module dltq_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dltq_pkg::dltq_cmd_t           cmd_i,
  output dltq_pkg::dltq_sts_t           sts_o,
  input  logic [dltq_pkg::MODE_W-1:0]   mode_i,
  input  logic [dltq_pkg::TID_W-1:0]    thread_id_i,
  input  logic [dltq_pkg::DELTA_W-1:0]  timeout_i,
  input  logic [dltq_pkg::TIME_W-1:0]   now_time_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          is_wake_o,
  output logic [dltq_pkg::TID_W-1:0]    woken_id_o,
  output logic [dltq_pkg::ST_W-1:0]     status_o,
  output logic [dltq_pkg::OCNT_W-1:0]   entry_count_o,
  output logic [dltq_pkg::TIME_W-1:0]   next_wake_time_o,
  output logic                          last_o
);
  import dltq_pkg::*;

  logic [ID_BITS-1:0] ids_mem [QUEUE_DEPTH];
  logic [DELTA_W-1:0] dlt_mem [QUEUE_DEPTH];

  logic [MODE_W-1:0]  mode_q;
  logic [ID_BITS-1:0] id_q;
  logic [DELTA_W-1:0] to_q;
  logic [TIME_W-1:0]  now_q;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [DELTA_W-1:0] total_q, total_d;
  logic [TIME_W-1:0]  lastc_q, lastc_d;
  logic [TIME_W-1:0]  hwt_q, hwt_d;
  logic [TIME_W-1:0]  ival_q, ival_d;
  logic [CNT_W-1:0]   ptr_q, ptr_d;
  logic [DELTA_W-1:0] prefix_q, prefix_d;
  logic [DELTA_W-1:0] rdel_q, rdel_d;
  logic [ST_W-1:0]    st_q, st_d;
  logic [ID_BITS-1:0] rd_id_q;
  logic [DELTA_W-1:0] rd_dlt_q;

  logic               ov_q, ov_d;
  logic               o_wake_q, o_wake_d;
  logic [TID_W-1:0]   o_id_q, o_id_d;
  logic [ST_W-1:0]    o_st_q, o_st_d;
  logic [OCNT_W-1:0]  o_cnt_q, o_cnt_d;
  logic [TIME_W-1:0]  o_nwt_q, o_nwt_d;
  logic               o_last_q, o_last_d;

  logic [IDX_W-1:0]   rd_addr, wr_addr;
  logic               wr_id_en, wr_dlt_en;
  logic [ID_BITS-1:0] wr_id;
  logic [DELTA_W-1:0] wr_dlt;
  logic [DELTA_W-1:0] pnew;
  logic               out_free;
  logic [CNT_W-1:0]   ptr_m1, ptr_p1;

  assign out_free = !ov_q || out_ready_i;
  assign pnew     = prefix_q - rd_dlt_q;
  assign ptr_m1   = ptr_q - CNT_W'(1);
  assign ptr_p1   = ptr_q + CNT_W'(1);

  always_comb begin
    sts_o.in_mode    = mode_i;
    sts_o.mode       = mode_q;
    sts_o.to_zero    = (to_q == '0);
    sts_o.out_free   = out_free;
    sts_o.exp_hit    = (count_q != '0) && (TIME_W'(rd_dlt_q) <= ival_q);
    sts_o.match      = (rd_id_q == id_q);
    sts_o.ptr_at_cnt = (ptr_q == count_q);
    sts_o.full       = (count_q >= CNT_W'(QUEUE_DEPTH));
    sts_o.append     = (to_q >= total_q);
    sts_o.ins_brk    = (pnew <= to_q) || (ptr_q == '0);
    sts_o.count      = count_q;
  end

  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    total_d   = total_q;
    lastc_d   = lastc_q;
    hwt_d     = hwt_q;
    ival_d    = ival_q;
    ptr_d     = ptr_q;
    prefix_d  = prefix_q;
    rdel_d    = rdel_q;
    st_d      = st_q;
    rd_addr   = head_q;
    wr_addr   = head_q;
    wr_id_en  = 1'b0;
    wr_dlt_en = 1'b0;
    wr_id     = rd_id_q;
    wr_dlt    = rd_dlt_q;
    ov_d      = ov_q && !out_ready_i;
    o_wake_d  = o_wake_q;
    o_id_d    = o_id_q;
    o_st_d    = o_st_q;
    o_cnt_d   = o_cnt_q;
    o_nwt_d   = o_nwt_q;
    o_last_d  = o_last_q;
    unique case (cmd_i.op)
      DP_NOP: begin
      end
      DP_LOAD: begin
        st_d = ST_OK;
      end
      DP_ADV: begin
        ival_d  = (now_q > lastc_q) ? (now_q - lastc_q) : '0;
        lastc_d = now_q;
        if (TIME_W'(total_q) < ival_d) begin
          total_d = '0;
        end else begin
          total_d = total_q - ival_d[DELTA_W-1:0];
        end
      end
      DP_EXP_RD: begin
      end
      DP_EXP_CHK: begin
        if (sts_o.exp_hit) begin
          // retire head and report it
          ival_d   = ival_q - TIME_W'(rd_dlt_q);
          head_d   = phys(head_q, CNT_W'(1));
          count_d  = count_q - CNT_W'(1);
          ov_d     = 1'b1;
          o_wake_d = 1'b1;
          o_id_d   = TID_W'(rd_id_q);
          o_st_d   = ST_OK;
          o_cnt_d  = OCNT_W'(count_d);
          o_nwt_d  = '0;
          o_last_d = 1'b0;
        end else if (count_q != '0) begin
          wr_dlt_en = 1'b1;
          wr_dlt    = rd_dlt_q - ival_q[DELTA_W-1:0];
        end
      end
      DP_FIND_INIT: begin
        ptr_d = '0;
      end
      DP_FIND_RD: begin
        rd_addr = phys(head_q, ptr_q);
      end
      DP_FIND_CHK: begin
        // hold the read on the matched slot for the remove walk
        rd_addr = phys(head_q, ptr_q);
        ptr_d   = ptr_p1;
      end
      DP_SET_ST: begin
        st_d = cmd_i.st;
      end
      DP_APPEND: begin
        wr_addr   = phys(head_q, count_q);
        wr_id_en  = 1'b1;
        wr_dlt_en = 1'b1;
        wr_id     = id_q;
        wr_dlt    = to_q - total_q;
        count_d   = count_q + CNT_W'(1);
        total_d   = to_q;
      end
      DP_INS_INIT: begin
        prefix_d = total_q;
        ptr_d    = count_q;
      end
      DP_INS_RD: begin
        rd_addr = phys(head_q, ptr_m1);
        ptr_d   = ptr_m1;
      end
      DP_INS_CHK: begin
        // move entry up one slot; trim it by the new entry's wait on the last step
        prefix_d  = pnew;
        wr_addr   = phys(head_q, ptr_p1);
        wr_id_en  = 1'b1;
        wr_dlt_en = 1'b1;
        if (sts_o.ins_brk) begin
          wr_dlt = rd_dlt_q - (to_q - pnew);
        end
      end
      DP_INS_PUT: begin
        wr_addr   = phys(head_q, ptr_q);
        wr_id_en  = 1'b1;
        wr_dlt_en = 1'b1;
        wr_id     = id_q;
        wr_dlt    = to_q - prefix_q;
        count_d   = count_q + CNT_W'(1);
      end
      DP_RM_INIT: begin
        rdel_d = rd_dlt_q;
        if (ptr_q == count_q) begin
          total_d = total_q - rd_dlt_q;
        end
      end
      DP_RM_RD: begin
        rd_addr = phys(head_q, ptr_q);
      end
      DP_RM_CHK: begin
        // shift down; the successor absorbs the removed wait
        wr_addr   = phys(head_q, ptr_m1);
        wr_id_en  = 1'b1;
        wr_dlt_en = 1'b1;
        wr_dlt    = rd_dlt_q + rdel_q;
        rdel_d    = '0;
        ptr_d     = ptr_p1;
      end
      DP_RM_DONE: begin
        count_d = count_q - CNT_W'(1);
      end
      DP_HW_RD: begin
      end
      DP_HW_SET: begin
        hwt_d = (count_q != '0) ? (lastc_q + TIME_W'(rd_dlt_q)) : '0;
      end
      DP_SUM: begin
        ov_d     = 1'b1;
        o_wake_d = 1'b0;
        o_id_d   = '0;
        o_st_d   = st_q;
        o_cnt_d  = OCNT_W'(count_q);
        o_nwt_d  = hwt_q;
        o_last_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_id_q  <= ids_mem[rd_addr];
    rd_dlt_q <= dlt_mem[rd_addr];
    if (wr_id_en) begin
      ids_mem[wr_addr] <= wr_id;
    end
    if (wr_dlt_en) begin
      dlt_mem[wr_addr] <= wr_dlt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_LOAD) begin
      mode_q <= mode_i;
      id_q   <= thread_id_i[ID_BITS-1:0];
      to_q   <= timeout_i;
      now_q  <= now_time_i;
    end
    ival_q   <= ival_d;
    ptr_q    <= ptr_d;
    prefix_q <= prefix_d;
    rdel_q   <= rdel_d;
    st_q     <= st_d;
    o_wake_q <= o_wake_d;
    o_id_q   <= o_id_d;
    o_st_q   <= o_st_d;
    o_cnt_q  <= o_cnt_d;
    o_nwt_q  <= o_nwt_d;
    o_last_q <= o_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      total_q <= '0;
      lastc_q <= '0;
      hwt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      total_q <= total_d;
      lastc_q <= lastc_d;
      hwt_q   <= hwt_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o      = ov_q;
  assign is_wake_o        = o_wake_q;
  assign woken_id_o       = o_id_q;
  assign status_o         = o_st_q;
  assign entry_count_o    = o_cnt_q;
  assign next_wake_time_o = o_nwt_q;
  assign last_o           = o_last_q;

endmodule

// File: hdl/dltq_ctrl.sv
// dltq_ctrl: sequencer for expire, lookup, insert walk and remove walk.
// Depends on dltq_pkg; commands dltq_datapath.
`timescale 1ns / 1ps
module dltq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dltq_pkg::dltq_sts_t  sts_i,
  output dltq_pkg::dltq_cmd_t  cmd_o
);
  import dltq_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o.op   = DP_NOP;
    cmd_o.st   = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          priority if (sts_i.in_mode == MODE_ADVANCE || sts_i.in_mode == MODE_ADD) begin
            state_d = S_ADV;
          end else if (sts_i.in_mode == MODE_REMOVE) begin
            state_d = S_FIND_INIT;
          end else begin
            state_d = S_SUM;
          end
        end
      end
      S_ADV: begin
        cmd_o.op = DP_ADV;
        state_d  = S_EXP_CHK;
      end
      S_EXP_RD: begin
        cmd_o.op = DP_EXP_RD;
        state_d  = S_EXP_CHK;
      end
      S_EXP_CHK: begin
        priority if (sts_i.exp_hit) begin
          // hold until the result register frees up
          if (sts_i.out_free) begin
            cmd_o.op = DP_EXP_CHK;
            state_d  = S_EXP_RD;
          end
        end else begin
          cmd_o.op = DP_EXP_CHK;
          state_d  = (sts_i.mode == MODE_ADD && !sts_i.to_zero) ? S_FIND_INIT : S_HW_RD;
        end
      end
      S_FIND_INIT: begin
        cmd_o.op = DP_FIND_INIT;
        state_d  = S_FIND_RD;
      end
      S_FIND_RD: begin
        priority if (!sts_i.ptr_at_cnt) begin
          cmd_o.op = DP_FIND_RD;
          state_d  = S_FIND_CHK;
        end else if (sts_i.mode == MODE_REMOVE) begin
          cmd_o.op = DP_SET_ST;
          cmd_o.st = ST_ABSENT;
          state_d  = S_HW_RD;
        end else if (sts_i.full) begin
          cmd_o.op = DP_SET_ST;
          cmd_o.st = ST_FULL;
          state_d  = S_HW_RD;
        end else if (sts_i.append) begin
          cmd_o.op = DP_APPEND;
          state_d  = S_HW_RD;
        end else begin
          cmd_o.op = DP_INS_INIT;
          state_d  = S_INS_RD;
        end
      end
      S_FIND_CHK: begin
        priority if (!sts_i.match) begin
          cmd_o.op = DP_FIND_CHK;
          state_d  = S_FIND_RD;
        end else if (sts_i.mode == MODE_REMOVE) begin
          cmd_o.op = DP_FIND_CHK;
          state_d  = S_RM_CHK;
        end else begin
          cmd_o.op = DP_SET_ST;
          cmd_o.st = ST_QUEUED;
          state_d  = S_HW_RD;
        end
      end
      S_RM_CHK: begin
        // entered once per remove; latches the removed entry's wait
        cmd_o.op = DP_RM_INIT;
        state_d  = S_RM_RD;
      end
      S_RM_RD: begin
        if (sts_i.ptr_at_cnt) begin
          cmd_o.op = DP_RM_DONE;
          state_d  = S_HW_RD;
        end else begin
          cmd_o.op = DP_RM_RD;
          state_d  = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        // shared slot: shift step of the remove walk
        if (sts_i.mode == MODE_REMOVE) begin
          cmd_o.op = DP_RM_CHK;
          state_d  = S_RM_RD;
        end else begin
          cmd_o.op = DP_INS_PUT;
          state_d  = S_HW_RD;
        end
      end
      S_INS_RD: begin
        cmd_o.op = DP_INS_RD;
        state_d  = S_INS_CHK;
      end
      S_INS_CHK: begin
        cmd_o.op = DP_INS_CHK;
        state_d  = sts_i.ins_brk ? S_INS_PUT : S_INS_RD;
      end
      S_HW_RD: begin
        cmd_o.op = DP_HW_RD;
        state_d  = S_HW_SET;
      end
      S_HW_SET: begin
        cmd_o.op = DP_HW_SET;
        state_d  = S_SUM;
      end
      S_SUM: begin
        if (sts_i.out_free) begin
          cmd_o.op = DP_SUM;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: bench/delta_list_timer_queue_test.sv
// delta_list_timer_queue_test: checks the delta-list timer queue against a
// cycle-free predictor of its sleeper list. Depends on dltq_pkg and dltq_if.
`timescale 1ns / 1ps
module delta_list_timer_queue_test;
  import dltq_pkg::*;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [TID_W-1:0]   tid;
    logic [DELTA_W-1:0] tmo;
    logic [TIME_W-1:0]  now;
  } request_t;

  typedef struct packed {
    logic               is_wake;
    logic [TID_W-1:0]   woken_id;
    logic [ST_W-1:0]    status;
    logic [OCNT_W-1:0]  entry_count;
    logic [TIME_W-1:0]  next_wake_time;
    logic               last;
  } wake_report_t;

  localparam int IDLE_LIMIT = 3000;

  logic clk_i;
  logic rst_ni;

  dltq_in_if  req_if ();
  dltq_out_if rsp_if ();

  delta_list_timer_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // Sleeper list as the block should hold it.
  logic [TID_W-1:0]   sleeper_id    [QUEUE_DEPTH+1];
  logic [DELTA_W-1:0] sleeper_delta [QUEUE_DEPTH+1];
  int                 sleeper_cnt;
  logic [DELTA_W-1:0] tail_wait;
  logic [TIME_W-1:0]  clock_seen;
  logic [TIME_W-1:0]  head_wake;

  request_t     pending_q [$];
  wake_report_t wake_q [$];

  int  errors;
  int  req_taken;
  int  idle_cycles;
  int  gap_left;
  int  stall_left;
  logic hold_off;
  logic in_took;
  logic [TIME_W-1:0] now_t;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got 0x%0h want 0x%0h at %0t", field, got, want, $time);
    errors++;
  endtask

  task automatic drop_sleeper(input int pos);
    for (int j = pos; j + 1 < sleeper_cnt; j++) begin
      sleeper_id[j]    = sleeper_id[j+1];
      sleeper_delta[j] = sleeper_delta[j+1];
    end
    sleeper_cnt--;
  endtask

  function automatic int find_sleeper(input logic [TID_W-1:0] tid);
    for (int i = 0; i < sleeper_cnt; i++) begin
      if (sleeper_id[i] == tid) return i;
    end
    return -1;
  endfunction

  task automatic predict_request(input request_t rq);
    logic [63:0]        span;
    logic [TID_W-1:0]   gone;
    logic [DELTA_W-1:0] prefix;
    logic [ST_W-1:0]    st;
    int                 pos;
    st = ST_OK;
    if (rq.mode == MODE_ADVANCE || rq.mode == MODE_ADD) begin
      span = (rq.now > clock_seen) ? 64'(rq.now - clock_seen) : 64'd0;
      clock_seen = rq.now;
      if (64'(tail_wait) < span) tail_wait = '0;
      else tail_wait = tail_wait - span[DELTA_W-1:0];
      while (sleeper_cnt > 0 && 64'(sleeper_delta[0]) <= span) begin
        span = span - 64'(sleeper_delta[0]);
        gone = sleeper_id[0];
        drop_sleeper(0);
        wake_q.push_back('{1'b1, gone, ST_OK, OCNT_W'(sleeper_cnt), '0, 1'b0});
      end
      if (sleeper_cnt > 0) sleeper_delta[0] = sleeper_delta[0] - span[DELTA_W-1:0];
    end
    if (rq.mode == MODE_ADD && rq.tmo != 0) begin
      if (find_sleeper(rq.tid) >= 0) begin
        st = ST_QUEUED;
      end else if (sleeper_cnt >= QUEUE_DEPTH) begin
        st = ST_FULL;
      end else if (rq.tmo >= tail_wait) begin
        sleeper_id[sleeper_cnt]    = rq.tid;
        sleeper_delta[sleeper_cnt] = rq.tmo - tail_wait;
        sleeper_cnt++;
        tail_wait = rq.tmo;
      end else begin
        // Walk back from the tail until the running deadline fits.
        prefix = tail_wait;
        pos = sleeper_cnt;
        while (pos > 0) begin
          pos--;
          prefix = prefix - sleeper_delta[pos];
          if (prefix <= rq.tmo) break;
        end
        for (int j = sleeper_cnt; j > pos; j--) begin
          sleeper_id[j]    = sleeper_id[j-1];
          sleeper_delta[j] = sleeper_delta[j-1];
        end
        sleeper_id[pos]      = rq.tid;
        sleeper_delta[pos]   = rq.tmo - prefix;
        sleeper_delta[pos+1] = sleeper_delta[pos+1] - sleeper_delta[pos];
        sleeper_cnt++;
      end
    end else if (rq.mode == MODE_REMOVE) begin
      pos = find_sleeper(rq.tid);
      if (pos < 0) begin
        st = ST_ABSENT;
      end else begin
        if (pos + 1 < sleeper_cnt) sleeper_delta[pos+1] += sleeper_delta[pos];
        else tail_wait = tail_wait - sleeper_delta[pos];
        drop_sleeper(pos);
      end
    end
    if (rq.mode != 2'd3) begin
      head_wake = (sleeper_cnt > 0) ? clock_seen + TIME_W'(sleeper_delta[0]) : '0;
    end
    wake_q.push_back('{1'b0, '0, st, OCNT_W'(sleeper_cnt), head_wake, 1'b1});
  endtask

  task automatic queue_request(input logic [MODE_W-1:0] mode, input logic [TID_W-1:0] tid,
                               input logic [DELTA_W-1:0] tmo, input logic [TIME_W-1:0] now);
    pending_q.push_back('{mode, tid, tmo, now});
  endtask

  // Mostly short sleeps on a small pool of threads so that lookups hit and
  // entries expire; now and then huge timeouts, stray IDs and clock jumps.
  task automatic queue_random_request();
    logic [MODE_W-1:0]  mode;
    logic [TID_W-1:0]   tid;
    logic [DELTA_W-1:0] tmo;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 52) mode = MODE_ADD;
    else if (pick < 80) mode = MODE_ADVANCE;
    else if (pick < 95) mode = MODE_REMOVE;
    else mode = 2'd3;
    tid = ($urandom_range(0, 9) == 0) ? TID_W'($urandom) : TID_W'($urandom_range(0, 23));
    pick = $urandom_range(0, 99);
    if (pick < 4) tmo = '0;
    else if (pick < 12) tmo = $urandom;
    else if (pick < 15) tmo = '1;
    else if (pick < 30) tmo = DELTA_W'($urandom_range(1, 5000));
    else tmo = DELTA_W'($urandom_range(1, 300));
    pick = $urandom_range(0, 99);
    if (pick < 3) now_t = TIME_W'({$urandom, $urandom});
    else if (pick < 8) now_t = now_t - TIME_W'($urandom_range(1, 100));
    else if (pick < 12) now_t = now_t + TIME_W'($urandom);
    else now_t = now_t + TIME_W'($urandom_range(0, 60));
    queue_request(mode, tid, tmo, now_t);
  endtask

  // Sender: hold a request until it is taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (req_if.valid && !in_took) begin
      req_if.valid <= 1'b1;
    end else if (gap_left > 0) begin
      req_if.valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_q.size() > 30 && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      gap_left <= $urandom_range(0, 2);
    end else if (pending_q.size() > 0) begin
      req_if.valid     <= 1'b1;
      req_if.mode      <= pending_q[0].mode;
      req_if.thread_id <= pending_q[0].tid;
      req_if.timeout   <= pending_q[0].tmo;
      req_if.now_time  <= pending_q[0].now;
      pending_q.pop_front();
    end else begin
      req_if.valid <= 1'b0;
    end
  end

  // Receiver: random stall bursts, a long hold-off, none near the end.
  always @(negedge clk_i) begin
    if (!rst_ni || hold_off) begin
      rsp_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (pending_q.size() > 30 && $urandom_range(0, 4) == 0) begin
      rsp_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (req_taken >= 40);
    @(negedge clk_i);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    @(negedge clk_i);
    hold_off = 1'b0;
  end

  always @(posedge clk_i) begin
    wake_report_t got;
    wake_report_t want;
    in_took <= req_if.valid && req_if.ready;
    if (rst_ni && req_if.valid && req_if.ready) begin
      predict_request('{req_if.mode, req_if.thread_id, req_if.timeout, req_if.now_time});
      req_taken++;
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.is_wake, rsp_if.woken_id, rsp_if.status, rsp_if.entry_count,
              rsp_if.next_wake_time, rsp_if.last};
      if (wake_q.size() == 0) begin
        report_mismatch("unexpected transaction", 64'(got.woken_id), 64'd0);
      end else begin
        want = wake_q.pop_front();
        if (got.is_wake != want.is_wake)
          report_mismatch("is_wake", 64'(got.is_wake), 64'(want.is_wake));
        if (got.woken_id != want.woken_id)
          report_mismatch("woken_id", 64'(got.woken_id), 64'(want.woken_id));
        if (got.status != want.status)
          report_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.entry_count != want.entry_count)
          report_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
        if (got.next_wake_time != want.next_wake_time)
          report_mismatch("next_wake_time", 64'(got.next_wake_time),
                          64'(want.next_wake_time));
        if (got.last != want.last)
          report_mismatch("last", 64'(got.last), 64'(want.last));
      end
    end
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[delta_list_timer_queue] ERROR");
      $finish;
    end
  end

  initial begin
    errors = 0; req_taken = 0; idle_cycles = 0; gap_left = 0; stall_left = 0;
    in_took = 1'b0; sleeper_cnt = 0; tail_wait = '0; clock_seen = '0; head_wake = '0;
    req_if.valid = 1'b0; req_if.mode = MODE_ADVANCE; req_if.thread_id = '0;
    req_if.timeout = '0; req_if.now_time = '0; rsp_if.ready = 1'b0;
    rst_ni = 1'b0;
    queue_request(MODE_ADVANCE, 8'd0,   32'd0,  48'd0);
    queue_request(MODE_ADD,     8'd0,   32'd1,  48'd0);
    queue_request(MODE_ADD,     8'd255, '1,     48'd0);
    queue_request(MODE_ADD,     8'd7,   32'd0,  48'd0);   // zero timeout
    queue_request(MODE_ADD,     8'd0,   32'd5,  48'd0);   // already queued
    queue_request(MODE_ADD,     8'd1,   32'd10, 48'd1);   // equal deadlines
    queue_request(MODE_ADD,     8'd2,   32'd10, 48'd1);
    queue_request(MODE_ADD,     8'd3,   32'd10, 48'd1);
    queue_request(MODE_ADD,     8'd4,   32'd5,  48'd2);   // insert mid-list
    queue_request(MODE_REMOVE,  8'd2,   '1,     '1);      // middle entry
    queue_request(MODE_REMOVE,  8'd255, 32'd0,  48'd2);   // tail entry
    queue_request(MODE_REMOVE,  8'd99,  32'd0,  48'd2);   // not queued
    queue_request(2'd3,         8'hff,  '1,     '1);
    queue_request(MODE_ADVANCE, 8'd0,   32'd0,  48'd11);  // retire equal deadlines
    queue_request(MODE_ADVANCE, 8'd0,   32'd0,  48'd5);   // clock backwards
    queue_request(MODE_ADD,     8'd9,   '1,     48'hffff_ffff_fff0); // wake time wraps
    queue_request(MODE_ADD,     8'd10,  32'd3,  48'hffff_ffff_fff2);
    queue_request(MODE_ADVANCE, 8'd0,   32'd0,  '1);
    queue_request(MODE_REMOVE,  8'd9,   32'd0,  48'd0);
    queue_request(MODE_ADVANCE, 8'd0,   32'd0,  48'd100);
    now_t = 48'd100;
    for (int k = 0; k < 3; k++) begin
      // Fill the list with long sleeps, overflow it, then drain with random work.
      for (int f = 0; f < 18; f++) queue_request(MODE_ADD, TID_W'(40 + f),
                                                 DELTA_W'($urandom_range(1, 2000)), now_t);
      repeat (20) queue_random_request();
      now_t = now_t + 48'd3000;
      queue_request(MODE_ADVANCE, 8'd0, 32'd0, now_t);
    end
    repeat (20) queue_random_request();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (pending_q.size() == 0 && !req_if.valid);
    wait (wake_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("[delta_list_timer_queue] OK");
    end else begin
      $display("[delta_list_timer_queue] ERROR");
    end
    $finish;
  end

endmodule
